// ===== design/fat16_chain_sector_walker_top_macros.svh =====
// Assertion macros shared by the FAT16 chain walker modules.
`ifndef FAT16_CHAIN_SECTOR_WALKER_TOP_MACROS_SVH
`define FAT16_CHAIN_SECTOR_WALKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCSW_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCSW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fcsw_pkg.sv =====
// Package: types, codes and constants of the FAT16 chain sector walker.
`default_nettype none

package fcsw_pkg;

    localparam int CLUSTER_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT  = 2;

    // input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_RUN    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // config register indexes
    localparam logic [1:0] REG_FAT_START  = 2'd0;
    localparam logic [1:0] REG_DATA_START = 2'd1;
    localparam logic [1:0] REG_SPC        = 2'd2;
    localparam logic [1:0] REG_SSL2       = 2'd3;

    localparam logic [7:0] SPC_RESET      = 8'd1;
    localparam logic [3:0] SSL2_MIN       = 4'd9;
    localparam logic [3:0] SSL2_MAX       = 4'd12;
    localparam logic [15:0] FIRST_CLUSTER = 16'd2;

    typedef struct packed {
        logic [31:0] fat_start;
        logic [31:0] data_start;
        logic [7:0]  spc;
        logic [3:0]  ssl2;
    } fcsw_cfg_t;

    // what the back end has to emit for one queued word
    typedef enum logic [2:0] {
        PLAN_ERROR,
        PLAN_LOOKUP,
        PLAN_RUN_LAST,
        PLAN_RUN_LOOKUP,
        PLAN_RUN_ERROR
    } fcsw_plan_t;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } fcsw_phase_t;

    typedef struct packed {
        fcsw_plan_t  plan;
        logic [15:0] run_cluster;   // cluster - 2
        logic [7:0]  run_count;
        logic [7:0]  fat_offset;
        logic [10:0] word_index;
        logic        need_read;
    } fcsw_cmd_t;

endpackage

`default_nettype wire

// ===== design/fcsw_queue.sv =====
// Small command queue between the front and back ends.
`default_nettype none

`include "fat16_chain_sector_walker_top_macros.svh"

module fcsw_queue #(
    parameter int DEPTH = fcsw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  fcsw_pkg::fcsw_cmd_t push_cmd,
    output logic                full,
    input  wire                 pop,
    output fcsw_pkg::fcsw_cmd_t head,
    output logic                head_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fcsw_pkg::fcsw_cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `FCSW_ASSERT_IMPL(a_no_push_full, aclk, aresetn, push, !full, "push into full queue")
    `FCSW_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, head_valid, "pop from empty queue")
    `FCSW_ASSERT_NEXT(a_drain_empty, aclk, aresetn, pop && !push && (count_reg == CW'(1)), !head_valid, "queue not empty after last pop")

endmodule

`default_nettype wire

// ===== design/fcsw_front.sv =====
// Front end: accepts input words, walks chain state, queues result plans.
`default_nettype none

module fcsw_front #(
    parameter int CLUSTER_BITS = fcsw_pkg::CLUSTER_BITS_DEFAULT
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  fcsw_pkg::fcsw_cfg_t cfg,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire                 s_opcode,
    input  wire  [15:0]         s_cluster_value,
    input  wire  [31:0]         s_file_size,
    input  wire                 q_full,
    output logic                q_push,
    output fcsw_pkg::fcsw_cmd_t q_cmd
);

    localparam logic [15:0] END_MARK = 16'((32'd1 << CLUSTER_BITS) - 32'd1);

    logic [CLUSTER_BITS-1:0] current_reg, current_next;
    logic [31:0]             remaining_reg, remaining_next;
    logic [7:0]              cached_off_reg, cached_off_next;
    logic                    cache_valid_reg, cache_valid_next;
    logic                    walking_reg, walking_next;

    logic        accept;
    logic [15:0] cv;
    logic [3:0]  lg;
    logic [3:0]  sh;
    logic [7:0]  off;
    logic [10:0] widx;
    logic        is_end;
    logic        is_low;
    logic [31:0] full_sec;
    logic        part;
    logic [31:0] need_sec;
    logic [7:0]  cnt_last;
    logic [7:0]  cnt;
    logic [31:0] used;
    logic [31:0] rem_after;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // cluster word masked to the configured width
    assign cv     = 16'(s_cluster_value[CLUSTER_BITS-1:0]);
    assign is_end = (cv == END_MARK);
    assign is_low = (cv < fcsw_pkg::FIRST_CLUSTER);

    // sector size clamped to 512..4096
    assign lg   = (cfg.ssl2 < fcsw_pkg::SSL2_MIN) ? fcsw_pkg::SSL2_MIN :
                  (cfg.ssl2 > fcsw_pkg::SSL2_MAX) ? fcsw_pkg::SSL2_MAX : cfg.ssl2;
    assign sh   = lg - 4'd1;
    assign off  = 8'(cv >> sh);
    assign widx = 11'(cv & ((16'd1 << sh) - 16'd1));

    // last-cluster count: ceil(remaining / sector), capped at the cluster size
    assign full_sec  = remaining_reg >> lg;
    assign part      = |(remaining_reg & ((32'd1 << lg) - 32'd1));
    assign need_sec  = full_sec + 32'(part);
    assign cnt_last  = (need_sec < 32'(cfg.spc)) ? need_sec[7:0] : cfg.spc;
    assign cnt       = is_end ? cnt_last : cfg.spc;
    assign used      = 32'(cnt) << lg;
    assign rem_after = (remaining_reg > used) ? remaining_reg - used : 32'd0;

    always_comb begin
        current_next     = current_reg;
        remaining_next   = remaining_reg;
        cached_off_next  = cached_off_reg;
        cache_valid_next = cache_valid_reg;
        walking_next     = walking_reg;
        q_push           = 1'b0;
        q_cmd.plan        = fcsw_pkg::PLAN_ERROR;
        q_cmd.run_cluster = 16'(current_reg) - fcsw_pkg::FIRST_CLUSTER;
        q_cmd.run_count   = cnt;
        q_cmd.fat_offset  = off;
        q_cmd.word_index  = widx;
        q_cmd.need_read   = !cache_valid_reg || (off != cached_off_reg);

        if (accept) begin
            if (s_opcode == fcsw_pkg::OP_START) begin
                q_push          = 1'b1;
                remaining_next  = s_file_size;
                q_cmd.need_read = 1'b1;
                if (is_low || is_end) begin
                    walking_next     = 1'b0;
                    cache_valid_next = 1'b0;
                    q_cmd.plan       = fcsw_pkg::PLAN_ERROR;
                end else begin
                    current_next     = cv[CLUSTER_BITS-1:0];
                    walking_next     = 1'b1;
                    cached_off_next  = off;
                    cache_valid_next = 1'b1;
                    q_cmd.plan       = fcsw_pkg::PLAN_LOOKUP;
                end
            end else if (walking_reg) begin
                // reply while idle is dropped
                q_push         = 1'b1;
                remaining_next = rem_after;
                if (is_end) begin
                    walking_next = 1'b0;
                    q_cmd.plan   = fcsw_pkg::PLAN_RUN_LAST;
                end else if (is_low) begin
                    walking_next = 1'b0;
                    q_cmd.plan   = fcsw_pkg::PLAN_RUN_ERROR;
                end else begin
                    current_next     = cv[CLUSTER_BITS-1:0];
                    cached_off_next  = off;
                    cache_valid_next = 1'b1;
                    q_cmd.plan       = fcsw_pkg::PLAN_RUN_LOOKUP;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_reg     <= '0;
            remaining_reg   <= '0;
            cached_off_reg  <= '0;
            cache_valid_reg <= 1'b0;
            walking_reg     <= 1'b0;
        end else begin
            current_reg     <= current_next;
            remaining_reg   <= remaining_next;
            cached_off_reg  <= cached_off_next;
            cache_valid_reg <= cache_valid_next;
            walking_reg     <= walking_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/fcsw_back.sv =====
// Back end: expands queued plans into result words through an output register.
`default_nettype none

`include "fat16_chain_sector_walker_top_macros.svh"

module fcsw_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  fcsw_pkg::fcsw_cfg_t cfg,
    input  fcsw_pkg::fcsw_cmd_t head,
    input  wire                 head_valid,
    output logic                pop,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [1:0]          m_kind,
    output logic [31:0]         m_sector_addr,
    output logic [7:0]          m_sector_count,
    output logic [10:0]         m_word_index,
    output logic                m_need_read,
    output logic                m_last
);

    fcsw_pkg::fcsw_phase_t phase_reg, phase_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  kind_reg;
    logic [31:0] addr_reg;
    logic [7:0]  count_reg;
    logic [10:0] widx_reg;
    logic        need_reg;
    logic        last_reg;

    logic        out_free;
    logic        load;
    logic        two_words;
    logic        in_second;
    logic [1:0]  res_kind;
    logic [23:0] run_prod;
    logic [31:0] res_addr;
    logic [7:0]  res_count;
    logic [10:0] res_widx;
    logic        res_need;
    logic        res_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign load      = out_free && head_valid;
    assign run_prod  = 24'(cfg.spc) * 24'(head.run_cluster);
    assign in_second = (phase_reg == fcsw_pkg::PH_SECOND);

    always_comb begin
        case (head.plan) inside
            fcsw_pkg::PLAN_RUN_LOOKUP, fcsw_pkg::PLAN_RUN_ERROR: two_words = 1'b1;
            default:                                               two_words = 1'b0;
        endcase
    end

    // phase sequencer
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            fcsw_pkg::PH_FIRST: begin
                if (load && two_words) begin
                    phase_next = fcsw_pkg::PH_SECOND;
                end
            end
            fcsw_pkg::PH_SECOND: begin
                if (load) begin
                    phase_next = fcsw_pkg::PH_FIRST;
                end
            end
            default: phase_next = fcsw_pkg::PH_FIRST;
        endcase
    end

    // which word to build this cycle
    always_comb begin
        pop      = 1'b0;
        res_kind = fcsw_pkg::KIND_ERROR;
        res_last = 1'b1;
        unique case (phase_reg)
            fcsw_pkg::PH_FIRST: begin
                pop = load && !two_words;
                case (head.plan) inside
                    fcsw_pkg::PLAN_ERROR: begin
                        res_kind = fcsw_pkg::KIND_ERROR;
                        res_last = 1'b1;
                    end
                    fcsw_pkg::PLAN_LOOKUP: begin
                        res_kind = fcsw_pkg::KIND_LOOKUP;
                        res_last = 1'b0;
                    end
                    default: begin
                        res_kind = fcsw_pkg::KIND_RUN;
                        res_last = (head.plan == fcsw_pkg::PLAN_RUN_LAST);
                    end
                endcase
            end
            fcsw_pkg::PH_SECOND: begin
                pop = load;
                if (head.plan == fcsw_pkg::PLAN_RUN_LOOKUP) begin
                    res_kind = fcsw_pkg::KIND_LOOKUP;
                    res_last = 1'b0;
                end else begin
                    res_kind = fcsw_pkg::KIND_ERROR;
                    res_last = 1'b1;
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    // fields of the selected word
    always_comb begin
        res_addr  = '0;
        res_count = '0;
        res_widx  = '0;
        res_need  = 1'b0;
        unique case (res_kind)
            fcsw_pkg::KIND_LOOKUP: begin
                res_addr = cfg.fat_start + 32'(head.fat_offset);
                res_widx = head.word_index;
                res_need = head.need_read;
            end
            fcsw_pkg::KIND_RUN: begin
                res_addr  = cfg.data_start + 32'(run_prod);
                res_count = head.run_count;
            end
            default: begin
                res_addr = '0;
            end
        endcase
    end

    assign m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= fcsw_pkg::PH_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= res_kind;
            addr_reg  <= res_addr;
            count_reg <= res_count;
            widx_reg  <= res_widx;
            need_reg  <= res_need;
            last_reg  <= res_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_sector_addr  = addr_reg;
    assign m_sector_count = count_reg;
    assign m_word_index   = widx_reg;
    assign m_need_read    = need_reg;
    assign m_last         = last_reg;

    `FCSW_ASSERT_IMPL(a_second_has_head, aclk, aresetn, in_second, head_valid, "no plan held")
    `FCSW_ASSERT_IMPL(a_pop_on_load, aclk, aresetn, pop, load, "pop without load")
    `FCSW_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid, "valid dropped")

endmodule

`default_nettype wire

// ===== design/fat16_chain_sector_walker_top.sv =====
// Top level of the FAT16 cluster chain to sector run walker.
// A word taken is queued at that edge; the back end then loads its first result word into the
//   output register, and shows it valid, once that register is free.
// Throughput: one input word per cycle while the queue is not full; the single output register
//   gives one result word per cycle while m_ready holds: a start one, a FAT reply one or two.
// Reset: synchronous, active low; clears walk state, queue and output valid, config to defaults.
`default_nettype none

module fat16_chain_sector_walker_top #(
    parameter int CLUSTER_BITS = fcsw_pkg::CLUSTER_BITS_DEFAULT,
    parameter int QUEUE_DEPTH  = fcsw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration write port
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_wdata,
    // input words: start of file or FAT entry reply
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_opcode,
    input  wire  [15:0] s_cluster_value,
    input  wire  [31:0] s_file_size,
    // result words: FAT lookup, data run or error
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_sector_addr,
    output logic [7:0]  m_sector_count,
    output logic [10:0] m_word_index,
    output logic        m_need_read,
    output logic        m_last
);

    // Config registers; the user must write them only while the walker is idle (the block does
    // not enforce this), so both ends read them live.
    fcsw_pkg::fcsw_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                fcsw_pkg::REG_FAT_START:  cfg_next.fat_start  = cfg_wdata;
                fcsw_pkg::REG_DATA_START: cfg_next.data_start = cfg_wdata;
                fcsw_pkg::REG_SPC:        cfg_next.spc        = cfg_wdata[7:0];
                fcsw_pkg::REG_SSL2:       cfg_next.ssl2       = cfg_wdata[3:0];
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fat_start  <= '0;
            cfg_reg.data_start <= '0;
            cfg_reg.spc        <= fcsw_pkg::SPC_RESET;
            cfg_reg.ssl2       <= fcsw_pkg::SSL2_MIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front -> queue -> back
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_head_valid;
    fcsw_pkg::fcsw_cmd_t q_push_cmd;
    fcsw_pkg::fcsw_cmd_t q_head;

    // Front: owns the chain state (current cluster, bytes left, FAT cache)
    // and decides per word which results follow.
    fcsw_front #(
        .CLUSTER_BITS(CLUSTER_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_cluster_value (s_cluster_value),
        .s_file_size     (s_file_size),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (q_push_cmd)
    );

    // Queue lets the input side keep taking words while results drain.
    fcsw_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    // Back: computes sector addresses (cluster multiply) and emits one or
    // two result words per queued plan.
    fcsw_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .head           (q_head),
        .head_valid     (q_head_valid),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_sector_addr  (m_sector_addr),
        .m_sector_count (m_sector_count),
        .m_word_index   (m_word_index),
        .m_need_read    (m_need_read),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

// ===== tb/tb_fat16_chain_sector_walker_top.sv =====
// Self-checking testbench for the FAT16 cluster chain sector walker top level.
`timescale 1ns / 100ps

module tb_fat16_chain_sector_walker_top;
    import fcsw_pkg::*;

    localparam int          CLUSTER_BITS    = CLUSTER_BITS_DEFAULT;
    // all-ones cluster value closes a chain
    localparam logic [15:0] END_MARK        = 16'((32'd1 << CLUSTER_BITS) - 1);
    localparam int          HOLD_CYCLES     = 400;   // long sink hold-off, fills the queue
    localparam int          QUIET_CYCLES    = 16;    // settle time before a register write
    localparam int          STALL_LIMIT     = 4000;  // watchdog: cycles with no word moving
    localparam int          WORDS_PER_PHASE = 255;
    localparam int          PHASES          = 6;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // one result word as it leaves the block
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [7:0]  count;
        logic [10:0] widx;
        logic        need;
        logic        last;
    } fat_req_t;

    // Tracks the walk the block should be doing and holds the FAT lookups,
    // data runs and error words it still owes.
    class walk_scoreboard;
        fcsw_cfg_t   cfg;
        logic [15:0] cur_cluster;
        logic [31:0] bytes_left;
        logic [7:0]  cached_off;
        bit          cache_ok;
        bit          walking;
        fat_req_t    due_reqs[$];
        int unsigned errors, lookups, runs, faults, words_in;

        function new();
            cfg         = '{32'd0, 32'd0, SPC_RESET, SSL2_MIN};
            cur_cluster = '0;
            bytes_left  = '0;
            cached_off  = '0;
            cache_ok    = 0;
            walking     = 0;
            errors      = 0;
            lookups     = 0;
            runs        = 0;
            faults      = 0;
            words_in    = 0;
        endfunction

        function int unsigned sector_shift();
            if (cfg.ssl2 < SSL2_MIN) return SSL2_MIN;
            if (cfg.ssl2 > SSL2_MAX) return SSL2_MAX;
            return cfg.ssl2;
        endfunction

        function int unsigned cluster_bytes();
            return 32'(cfg.spc) << sector_shift();
        endfunction

        function int pending();
            return due_reqs.size();
        endfunction

        function fat_req_t make_req(logic [1:0] kind, logic [31:0] addr, logic [7:0] count,
                                    logic [10:0] widx, logic need, logic last);
            fat_req_t r;
            r.kind  = kind;
            r.addr  = addr;
            r.count = count;
            r.widx  = widx;
            r.need  = need;
            r.last  = last;
            return r;
        endfunction

        function string show(fat_req_t r);
            return $sformatf("kind=%0d addr=%08h cnt=%0d widx=%0d need=%0d last=%0d",
                             r.kind, r.addr, r.count, r.widx, r.need, r.last);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
        endfunction

        // FAT entry lookup; the cached sector is the last one asked for
        function void push_lookup(logic [15:0] cl);
            int unsigned sh;
            logic [7:0]  off;
            logic [10:0] widx;
            logic        need;
            sh   = sector_shift() - 1;
            off  = 8'(32'(cl) >> sh);
            widx = 11'(32'(cl) & ((32'd1 << sh) - 32'd1));
            need = !cache_ok || (off != cached_off);
            cached_off = off;
            cache_ok   = 1;
            due_reqs.push_back(make_req(KIND_LOOKUP, cfg.fat_start + 32'(off), 8'd0, widx,
                                        need, 1'b0));
        endfunction

        // Accepted input word; returns how many result words it causes.
        function int note_word(logic op, logic [15:0] value, logic [31:0] size);
            logic [15:0] cl;
            logic [31:0] run_addr, cnt, used, want_secs;
            int unsigned sh;
            cl = value & END_MARK;
            words_in++;
            if (op == OP_START) begin
                bytes_left = size;
                cache_ok   = 0;
                if (cl < FIRST_CLUSTER || cl == END_MARK) begin
                    walking = 0;
                    due_reqs.push_back(make_req(KIND_ERROR, 32'd0, 8'd0, 11'd0, 1'b0, 1'b1));
                    return 1;
                end
                cur_cluster = cl;
                walking     = 1;
                push_lookup(cl);
                return 1;
            end
            if (!walking) return 0;

            sh       = sector_shift();
            run_addr = cfg.data_start + 32'(cfg.spc) * (32'(cur_cluster) - 32'd2);
            if (cl == END_MARK) begin
                // last cluster: only the sectors still holding file bytes
                want_secs = (bytes_left >> sh)
                          + 32'((bytes_left & ((32'd1 << sh) - 32'd1)) != 32'd0);
                cnt = (want_secs < 32'(cfg.spc)) ? want_secs : 32'(cfg.spc);
            end else begin
                cnt = 32'(cfg.spc);
            end
            used       = cnt << sh;
            bytes_left = (bytes_left > used) ? bytes_left - used : 32'd0;

            if (cl == END_MARK) begin
                walking = 0;
                due_reqs.push_back(make_req(KIND_RUN, run_addr, 8'(cnt), 11'd0, 1'b0, 1'b1));
                return 1;
            end
            due_reqs.push_back(make_req(KIND_RUN, run_addr, 8'(cnt), 11'd0, 1'b0, 1'b0));
            if (cl < FIRST_CLUSTER) begin
                // broken chain
                walking = 0;
                due_reqs.push_back(make_req(KIND_ERROR, 32'd0, 8'd0, 11'd0, 1'b0, 1'b1));
                return 2;
            end
            cur_cluster = cl;
            push_lookup(cl);
            return 2;
        endfunction

        function void check_word(fat_req_t got);
            fat_req_t want;
            string    diff;
            if (due_reqs.size() == 0) begin
                flag({"result word with nothing expected: ", show(got)});
                return;
            end
            want = due_reqs.pop_front();
            diff = "";
            if (got.kind  !== want.kind)  diff = {diff, " kind"};
            if (got.addr  !== want.addr)  diff = {diff, " sector_addr"};
            if (got.count !== want.count) diff = {diff, " sector_count"};
            if (got.widx  !== want.widx)  diff = {diff, " word_index"};
            if (got.need  !== want.need)  diff = {diff, " need_read"};
            if (got.last  !== want.last)  diff = {diff, " last"};
            if (diff != "")
                flag({"mismatch on", diff, ": expected ", show(want), " got ", show(got)});
            if (want.kind == KIND_LOOKUP) lookups++;
            else if (want.kind == KIND_RUN) runs++;
            else faults++;
        endfunction

        function void close_out();
            while (due_reqs.size() != 0)
                flag({"expected word never came: ", show(due_reqs.pop_front())});
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT hookup
    // ------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_opcode;
    logic [15:0] s_cluster_value;
    logic [31:0] s_file_size;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [31:0] m_sector_addr;
    logic [7:0]  m_sector_count;
    logic [10:0] m_word_index;
    logic        m_need_read;
    logic        m_last;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    fat16_chain_sector_walker_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_cluster_value (s_cluster_value),
        .s_file_size     (s_file_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_sector_addr   (m_sector_addr),
        .m_sector_count  (m_sector_count),
        .m_word_index    (m_word_index),
        .m_need_read     (m_need_read),
        .m_last          (m_last)
    );

    walk_scoreboard sb = new();

    idle_mode_t  idle_mode = IDLE_NONE;
    bit          hold_req  = 0;   // stimulus asks the sink for one long hold-off
    int          hold_left = 0;
    int unsigned words_live = 0;  // accepted words that caused results
    int unsigned idle_run   = 0;

    // Percent chance per cycle that a side idles (sender) or stalls (sink).
    function automatic int stall_pct(bit sender);
        case (idle_mode)
            IDLE_SEND: return sender ? 64 : 0;
            IDLE_RECV: return sender ? 0 : 64;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers. All called at a rising edge; inputs change by NBA only.
    // ------------------------------------------------------------------

    // Offer one input word, after a random idle gap, and wait for it to be taken.
    task automatic send_word(logic op, logic [15:0] value, logic [31:0] size);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < stall_pct(1'b1)) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_cluster_value <= value;
        s_file_size     <= size;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (sb.note_word(op, value, size) > 0) words_live++;
    endtask

    // One register write; write enable is lowered by the caller.
    task automatic put_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic program_regs(fcsw_cfg_t c);
        put_reg(REG_FAT_START,  c.fat_start);
        put_reg(REG_DATA_START, c.data_start);
        put_reg(REG_SPC,        32'(c.spc));
        put_reg(REG_SSL2,       32'(c.ssl2));
        cfg_we <= 1'b0;
        sb.cfg = c;
    endtask

    // Stop offering, wait for every owed word and for the sink hold-off to end, then
    // idle for QUIET_CYCLES before the next step.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0 || hold_req || hold_left != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // A well-formed file: start, a chain of replies with random content, and
    // usually the end marker. Some chains break on a low cluster word, some
    // are left open so the next start abandons them.
    task automatic send_file();
        logic [15:0] cl, nxt;
        logic [31:0] size;
        int unsigned links, span, pick;
        links = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(5);
        span  = (links + 1) * sb.cluster_bytes();
        pick  = $urandom_range(9);
        if (pick < 3)       size = $urandom();
        else if (pick == 3) size = 32'd0;
        else if (pick == 4) size = span;            // exactly fills the chain
        else                size = $urandom_range(span);
        cl = 16'($urandom_range(32'hFFFE, 2));
        send_word(OP_START, cl, size);
        repeat (links) begin
            pick = $urandom_range(9);
            // mostly nearby clusters, so the FAT sector cache gets hits
            if (pick < 5)      nxt = cl + 16'd1;
            else if (pick < 8) nxt = cl + 16'($urandom_range(600));
            else               nxt = 16'($urandom());
            send_word(OP_REPLY, nxt, $urandom());
            if (nxt < FIRST_CLUSTER || nxt == END_MARK) return;
            cl = nxt;
        end
        pick = $urandom_range(9);
        if (pick < 8)       send_word(OP_REPLY, END_MARK, $urandom());
        else if (pick == 8) send_word(OP_REPLY, 16'($urandom_range(1)), $urandom());
    endtask

    // Noise: stray replies and starts on reserved cluster values.
    task automatic send_noise();
        case ($urandom_range(2))
            0:       send_word(OP_REPLY, 16'($urandom()), $urandom());
            1:       send_word(OP_START, 16'($urandom_range(1)), $urandom());
            default: send_word(OP_START, END_MARK, $urandom());
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result sink: checks each taken word, randomizes ready, and runs the
    // long hold-off when asked (counted here, in its own process).
    // ------------------------------------------------------------------
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_word(sb.make_req(m_kind, m_sector_addr, m_sector_count,
                                          m_word_index, m_need_read, m_last));
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct(1'b0));
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", idle_run);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        fcsw_cfg_t   plan_cfg [PHASES];
        idle_mode_t  plan_idle [PHASES];
        int unsigned target;

        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_FAT_START;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_opcode        = OP_START;
        s_cluster_value = '0;
        s_file_size     = '0;

        // register settings per phase: wrapping bases, cluster sizes of 0, 1,
        // 128 and 255, sector size codes below, inside and above 9..12
        plan_cfg[0] = '{32'h0000_0100, 32'h0000_2000, 8'd4, 4'd9};
        plan_cfg[1] = '{32'hFFFF_FFF0, 32'hFFFF_FF00, 8'd128, 4'd12};
        plan_cfg[2] = '{$urandom(), $urandom(), 8'd1, 4'd10};
        plan_cfg[3] = '{32'd0, 32'd0, 8'd0, 4'd0};
        plan_cfg[4] = '{$urandom(), $urandom(), 8'd255, 4'd15};
        plan_cfg[5] = '{$urandom(), $urandom(), 8'($urandom_range(128, 1)), 4'd11};
        plan_idle   = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_RECV, IDLE_BOTH};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words, reset register values (one sector per cluster, 512 B).
        send_word(OP_REPLY, 16'h1234, 32'h0);           // reply while idle: dropped
        send_word(OP_START, 16'h0000, 32'h0);           // bad first cluster
        send_word(OP_START, 16'h0001, 32'hFFFF_FFFF);
        send_word(OP_START, END_MARK, 32'h5555_5555);
        send_word(OP_REPLY, 16'h0005, 32'hAAAA_AAAA);   // still idle after error
        send_word(OP_START, 16'h0002, 32'h0);           // empty file: zero-length run
        send_word(OP_REPLY, END_MARK, 32'h0);
        send_word(OP_START, 16'hFFFE, 32'hFFFF_FFFF);   // top cluster, max size
        send_word(OP_REPLY, 16'h0003, 32'h0);
        send_word(OP_REPLY, 16'h0004, 32'h0);           // same FAT sector, no reread
        send_word(OP_REPLY, 16'h0000, 32'h0);           // broken chain
        send_word(OP_START, 16'h0100, 32'd700);
        send_word(OP_REPLY, 16'h0101, 32'h0);
        send_word(OP_START, 16'h8000, 32'd1);           // abandons the open walk
        send_word(OP_REPLY, 16'h0001, 32'h0);           // broken chain on 1
        send_word(OP_START, 16'h7FFF, 32'd513);         // tail capped at cluster size
        send_word(OP_REPLY, END_MARK, 32'h0);
        send_word(OP_START, 16'h0010, 32'h8000_0000);
        send_word(OP_REPLY, 16'h0011, 32'h7FFF_FFFF);
        send_word(OP_REPLY, END_MARK, 32'h0);
        send_word(OP_START, 16'h0020, 32'd100);         // size runs out before the end
        send_word(OP_REPLY, 16'h0021, 32'h0);
        send_word(OP_REPLY, END_MARK, 32'h0);
        drain();

        // Random phases; each starts from a quiet block with new registers.
        for (int p = 0; p < PHASES; p++) begin
            program_regs(plan_cfg[p]);
            idle_mode = plan_idle[p];
            if (plan_idle[p] == IDLE_RECV) hold_req = 1;
            target = words_live + WORDS_PER_PHASE;
            while (words_live < target) begin
                if ($urandom_range(9) == 0) send_noise();
                else                        send_file();
            end
            drain();
        end

        sb.close_out();
        $display("Run covered %0d input words (%0d with results) over %0d register settings",
                 sb.words_in, words_live, PHASES + 1);
        $display("and checked %0d FAT lookups, %0d data runs, %0d error words; %0d failures.",
                 sb.lookups, sb.runs, sb.faults, sb.errors);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/fcsw_pkg.sv
design/fcsw_queue.sv
design/fcsw_front.sv
design/fcsw_back.sv
design/fat16_chain_sector_walker_top.sv
tb/tb_fat16_chain_sector_walker_top.sv
